// File: rtl/core/elmd_pkg.sv
// ----------------------------------------------------------------------------
// elmd_pkg
// Shared types and constants for the efuse logical map decoder: operation
// codes passed from the parser to the result stage, status codes and the
// fixed logical addresses of the captured trim and front end bytes.
// ----------------------------------------------------------------------------
package elmd_pkg;

   // Operation codes carried through the queue.
   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_SUM_MAC = 2'd1;
   localparam logic [1:0] OP_SUM_OVR = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   // Summary status codes.
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MAC  = 2'd1;
   localparam logic [1:0] STAT_OVR  = 2'd2;

   // Full logical index width: block (7 bits), word (2 bits), byte (1 bit).
   localparam int LIDX_W = 10;

   // Logical addresses of captured bytes.
   localparam logic [LIDX_W-1:0] CAP_INDEX = 10'h0B9;
   localparam logic [LIDX_W-1:0] RFE_INDEX = 10'h0CA;
   localparam int                MAC_BYTES = 6;

   // Header decoding constants.
   localparam logic [7:0] TERM_BYTE = 8'hFF;
   localparam logic [4:0] EXT_CODE  = 5'h0F;

   // Queue sizing.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // One operation for the result stage.
   typedef struct packed {
      logic [1:0]        code;
      logic              clr;
      logic [LIDX_W-1:0] idx;
      logic [7:0]        data;
   } op_type;

   // Queue status seen by the top level and the result stage.
   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } q_status_type;

endpackage

// File: rtl/core/elmd_front.sv
// ----------------------------------------------------------------------------
// elmd_front
// Record parser. Takes one physical byte per transaction, walks the header
// and word structure and produces up to two operations per byte.
// ----------------------------------------------------------------------------
module elmd_front #(
   parameter int PHY_BYTES  = 512,
   parameter int PROT_BYTES = 96,
   parameter int LOG_BYTES  = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  logic             first_byte,
   input  logic [7:0]       phy_byte,
   output logic [1:0]       push_cnt,
   output elmd_pkg::op_type push0,
   output elmd_pkg::op_type push1
);

   localparam int REGION_END = (PHY_BYTES > PROT_BYTES) ? (PHY_BYTES - PROT_BYTES) : 0;
   localparam int POS_W      = $clog2(REGION_END + 4);
   localparam int LIDX_W_L   = elmd_pkg::LIDX_W;

   localparam logic [1:0] PH_DONE = 2'd0;
   localparam logic [1:0] PH_HDR  = 2'd1;
   localparam logic [1:0] PH_HDR2 = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [2:0]       held_ff, held_in;
   logic [6:0]       block_ff, block_in;
   logic [3:0]       mask_ff, mask_in;
   logic [1:0]       slot_ff, slot_in;
   logic             biw_ff, biw_in;

   logic [1:0]       cur_phase;
   logic             adv_go;
   logic [2:0]       adv_start;
   logic             adv_found;
   logic [1:0]       adv_slot;
   logic [LIDX_W_L-1:0] adv_lidx;
   logic             wr_v;
   logic             sum_v;
   logic [1:0]       sum_code;
   elmd_pkg::op_type wr_op;
   elmd_pkg::op_type sum_op;

   // Lowest present word at or above the start slot.
   always_comb begin
      adv_found = 1'b0;
      adv_slot  = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if ((3'(i) >= adv_start) && !mask_in[i]) begin
            adv_found = 1'b1;
            adv_slot  = 2'(i);
         end
      end
   end

   assign adv_lidx = {block_in, adv_slot, 1'b0};

   // Parser next state and operation generation.
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      held_in   = held_ff;
      block_in  = block_ff;
      mask_in   = mask_ff;
      slot_in   = slot_ff;
      biw_in    = biw_ff;
      cur_phase = phase_ff;
      adv_go    = 1'b0;
      adv_start = 3'd0;
      wr_v      = 1'b0;
      sum_v     = 1'b0;
      sum_code  = elmd_pkg::OP_SUM_MAC;
      if (req_accept) begin
         if (first_byte) begin
            pos_in    = '0;
            held_in   = 3'd0;
            block_in  = 7'd0;
            mask_in   = 4'hF;
            slot_in   = 2'd0;
            biw_in    = 1'b0;
            cur_phase = PH_HDR;
            phase_in  = PH_HDR;
         end
         if (first_byte && (REGION_END == 0)) begin
            sum_v    = 1'b1;
            phase_in = PH_DONE;
         end else begin
            case (cur_phase)
               PH_HDR: begin
                  if (phy_byte == elmd_pkg::TERM_BYTE) begin
                     sum_v    = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     pos_in = pos_in + 1'b1;
                     if (phy_byte[4:0] == elmd_pkg::EXT_CODE) begin
                        held_in  = phy_byte[7:5];
                        phase_in = PH_HDR2;
                     end else begin
                        block_in = {3'd0, phy_byte[7:4]};
                        mask_in  = phy_byte[3:0];
                        adv_go   = 1'b1;
                     end
                  end
               end
               PH_HDR2: begin
                  if (phy_byte == elmd_pkg::TERM_BYTE) begin
                     sum_v    = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     pos_in   = pos_in + 1'b1;
                     block_in = {phy_byte[7:4], held_ff};
                     mask_in  = phy_byte[3:0];
                     adv_go   = 1'b1;
                  end
               end
               PH_DATA: begin
                  wr_v   = 1'b1;
                  pos_in = pos_in + 1'b1;
                  if (!biw_ff) begin
                     biw_in = 1'b1;
                  end else begin
                     adv_go    = 1'b1;
                     adv_start = {1'b0, slot_ff} + 3'd1;
                  end
               end
               default: begin
               end
            endcase

            // Move on to the next present word or the next header.
            if (adv_go) begin
               if (adv_found) begin
                  if ((pos_in + POS_W'(2) > POS_W'(REGION_END)) ||
                      ({1'b0, adv_lidx} + 11'd2 > 11'(LOG_BYTES))) begin
                     sum_v    = 1'b1;
                     sum_code = elmd_pkg::OP_SUM_OVR;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_DATA;
                     slot_in  = adv_slot;
                     biw_in   = 1'b0;
                  end
               end else begin
                  phase_in = PH_HDR;
                  slot_in  = 2'd0;
                  biw_in   = 1'b0;
                  if (pos_in >= POS_W'(REGION_END)) begin
                     sum_v    = 1'b1;
                     phase_in = PH_DONE;
                  end
               end
            end
         end
      end
   end

   // Pack the operations; the write always precedes the summary.
   always_comb begin
      wr_op.code  = elmd_pkg::OP_WRITE;
      wr_op.clr   = 1'b0;
      wr_op.idx   = {block_ff, slot_ff, biw_ff};
      wr_op.data  = phy_byte;
      sum_op.code = sum_code;
      sum_op.clr  = first_byte;
      sum_op.idx  = '0;
      sum_op.data = 8'd0;
      push0       = sum_op;
      push1       = sum_op;
      push_cnt    = 2'd0;
      if (req_accept) begin
         if (wr_v) begin
            push0    = wr_op;
            push_cnt = sum_v ? 2'd2 : 2'd1;
         end else if (sum_v) begin
            push_cnt = 2'd1;
         end else if (first_byte) begin
            push0.code = elmd_pkg::OP_CLEAR;
            push_cnt   = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         pos_ff   <= '0;
         held_ff  <= 3'd0;
         block_ff <= 7'd0;
         mask_ff  <= 4'hF;
         slot_ff  <= 2'd0;
         biw_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         held_ff  <= held_in;
         block_ff <= block_in;
         mask_ff  <= mask_in;
         slot_ff  <= slot_in;
         biw_ff   <= biw_in;
      end
   end

endmodule

// File: rtl/core/elmd_queue.sv
// ----------------------------------------------------------------------------
// elmd_queue
// Short operation queue between parser and result stage. Takes up to two
// operations per cycle and releases one.
// ----------------------------------------------------------------------------
module elmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_cnt,
   input  elmd_pkg::op_type       push0,
   input  elmd_pkg::op_type       push1,
   input  logic                   pop,
   output elmd_pkg::op_type       head,
   output elmd_pkg::q_status_type status
);

   elmd_pkg::op_type                 entry_ff [elmd_pkg::QUEUE_DEPTH];
   logic [elmd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [elmd_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [elmd_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic [elmd_pkg::QPTR_W-1:0]      wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_cnt;
      rd_ptr_in = rd_ptr_ff + {{(elmd_pkg::QPTR_W-1){1'b0}}, pop};
      count_in  = count_ff + {{(elmd_pkg::QCNT_W-2){1'b0}}, push_cnt}
                  - {{(elmd_pkg::QCNT_W-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ptr_next] <= push1;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

// File: rtl/core/elmd_back.sv
// ----------------------------------------------------------------------------
// elmd_back
// Result stage. Applies each operation to the captured fields and loads the
// result register that drives the response channel.
// ----------------------------------------------------------------------------
module elmd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [8:0]             mac_offset,
   input  elmd_pkg::op_type       head,
   input  elmd_pkg::q_status_type q_status,
   output logic                   pop,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic [8:0]             rsp_log_index,
   output logic [7:0]             rsp_log_byte,
   output logic [1:0]             rsp_status,
   output logic [47:0]            rsp_mac_address,
   output logic [5:0]             rsp_xtal_trim,
   output logic [4:0]             rsp_rf_front_end,
   output logic                   rsp_package_type,
   output logic                   rsp_last
);

   logic [47:0] mac_ff, mac_in;
   logic [7:0]  cap_ff, cap_in;
   logic [7:0]  rfe_ff, rfe_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [8:0]  index_ff, index_in;
   logic [7:0]  byte_ff, byte_in;
   logic [1:0]  status_ff, status_in;
   logic [47:0] mac_out_ff, mac_out_in;
   logic [5:0]  cap_out_ff, cap_out_in;
   logic [4:0]  rfe_out_ff, rfe_out_in;
   logic        pkg_ff, pkg_in;

   logic [47:0] base_mac;
   logic [7:0]  base_cap;
   logic [7:0]  base_rfe;
   logic [10:0] mac_diff;
   logic        mac_hit;
   logic        is_write;

   assign pop      = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign is_write = (head.code == elmd_pkg::OP_WRITE);
   assign mac_diff = {1'b0, head.idx} - {2'b00, mac_offset};
   assign mac_hit  = ({1'b0, head.idx} >= {2'b00, mac_offset}) &&
                     (mac_diff < 11'(elmd_pkg::MAC_BYTES));

   // Captured fields: clear first if the operation opens a dump.
   always_comb begin
      base_mac = head.clr ? 48'hFFFF_FFFF_FFFF : mac_ff;
      base_cap = head.clr ? 8'hFF : cap_ff;
      base_rfe = head.clr ? 8'hFF : rfe_ff;
      mac_in   = mac_ff;
      cap_in   = cap_ff;
      rfe_in   = rfe_ff;
      if (pop) begin
         mac_in = base_mac;
         cap_in = base_cap;
         rfe_in = base_rfe;
         if (is_write) begin
            for (int k = 0; k < elmd_pkg::MAC_BYTES; k++) begin
               if (mac_hit && (mac_diff[2:0] == 3'(k))) begin
                  mac_in[47 - 8 * k -: 8] = head.data;
               end
            end
            if (head.idx == elmd_pkg::CAP_INDEX) begin
               cap_in = head.data;
            end
            if (head.idx == elmd_pkg::RFE_INDEX) begin
               rfe_in = head.data;
            end
         end
      end
   end

   // Result register load.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      index_in     = index_ff;
      byte_in      = byte_ff;
      status_in    = status_ff;
      mac_out_in   = mac_out_ff;
      cap_out_in   = cap_out_ff;
      rfe_out_in   = rfe_out_ff;
      pkg_in       = pkg_ff;
      if (pop) begin
         rsp_valid_in = (head.code != elmd_pkg::OP_CLEAR);
         if (is_write) begin
            kind_in    = 1'b0;
            index_in   = head.idx[8:0];
            byte_in    = head.data;
            status_in  = elmd_pkg::STAT_OK;
            mac_out_in = 48'd0;
            cap_out_in = 6'd0;
            rfe_out_in = 5'd0;
            pkg_in     = 1'b0;
         end else begin
            kind_in    = 1'b1;
            index_in   = 9'd0;
            byte_in    = 8'd0;
            if (head.code == elmd_pkg::OP_SUM_OVR) begin
               status_in = elmd_pkg::STAT_OVR;
            end else if ((base_mac == 48'd0) || (base_mac == 48'hFFFF_FFFF_FFFF)) begin
               status_in = elmd_pkg::STAT_MAC;
            end else begin
               status_in = elmd_pkg::STAT_OK;
            end
            mac_out_in = base_mac;
            cap_out_in = base_cap[5:0];
            rfe_out_in = base_rfe[4:0];
            pkg_in     = base_rfe[5];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mac_ff       <= 48'hFFFF_FFFF_FFFF;
         cap_ff       <= 8'hFF;
         rfe_ff       <= 8'hFF;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         mac_ff       <= mac_in;
         cap_ff       <= cap_in;
         rfe_ff       <= rfe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      index_ff   <= index_in;
      byte_ff    <= byte_in;
      status_ff  <= status_in;
      mac_out_ff <= mac_out_in;
      cap_out_ff <= cap_out_in;
      rfe_out_ff <= rfe_out_in;
      pkg_ff     <= pkg_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_log_index    = index_ff;
   assign rsp_log_byte     = byte_ff;
   assign rsp_status       = status_ff;
   assign rsp_mac_address  = mac_out_ff;
   assign rsp_xtal_trim    = cap_out_ff;
   assign rsp_rf_front_end = rfe_out_ff;
   assign rsp_package_type = pkg_ff;
   assign rsp_last         = kind_ff;

endmodule

// File: rtl/core/efuse_logical_map_decoder_top.sv
// Results: each operation from an accepted byte is written into the operation
// queue and then into the result register that drives the response port.
// Throughput: one physical byte per cycle; the input stalls only while the
// four-entry operation queue holds three or more entries.
// Reset: synchronous, active high; parser idle until a first byte, captured
// fields all ones, MAC offset register 208.
// ----------------------------------------------------------------------------
// efuse_logical_map_decoder_top
// Decodes packed efuse records into logical map writes and a summary
// transaction per dump. Parser and result stage are joined by a short queue.
// ----------------------------------------------------------------------------
module efuse_logical_map_decoder_top #(
   parameter int PHY_BYTES  = 512,
   parameter int PROT_BYTES = 96,
   parameter int LOG_BYTES  = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_first_byte,
   input  logic [7:0]  req_phy_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [8:0]  rsp_log_index,
   output logic [7:0]  rsp_log_byte,
   output logic [1:0]  rsp_status,
   output logic [47:0] rsp_mac_address,
   output logic [5:0]  rsp_xtal_trim,
   output logic [4:0]  rsp_rf_front_end,
   output logic        rsp_package_type,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [8:0]  csr_write_data
);

   logic [8:0]             csr_mac_offset_ff;
   logic                   req_accept;
   logic [1:0]             push_cnt;
   elmd_pkg::op_type       push0;
   elmd_pkg::op_type       push1;
   elmd_pkg::op_type       q_head;
   elmd_pkg::q_status_type q_status;
   logic                   q_pop;

   // MAC offset register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_mac_offset_ff <= 9'd208;
      end else if (csr_write_enable) begin
         csr_mac_offset_ff <= csr_write_data;
      end
   end

   // Hold off input when the queue cannot take two more operations.
   assign req_stall  = (q_status.count > elmd_pkg::QCNT_W'(elmd_pkg::QUEUE_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;

   elmd_front #(
      .PHY_BYTES  (PHY_BYTES),
      .PROT_BYTES (PROT_BYTES),
      .LOG_BYTES  (LOG_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .first_byte (req_first_byte),
      .phy_byte   (req_phy_byte),
      .push_cnt   (push_cnt),
      .push0      (push0),
      .push1      (push1)
   );

   elmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (push_cnt),
      .push0    (push0),
      .push1    (push1),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   elmd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .mac_offset       (csr_mac_offset_ff),
      .head             (q_head),
      .q_status         (q_status),
      .pop              (q_pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_log_index    (rsp_log_index),
      .rsp_log_byte     (rsp_log_byte),
      .rsp_status       (rsp_status),
      .rsp_mac_address  (rsp_mac_address),
      .rsp_xtal_trim    (rsp_xtal_trim),
      .rsp_rf_front_end (rsp_rf_front_end),
      .rsp_package_type (rsp_package_type),
      .rsp_last         (rsp_last)
   );

   // The queue never holds more than its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= elmd_pkg::QCNT_W'(elmd_pkg::QUEUE_DEPTH))
      else $error("operation queue overflow");

   // Operations enter the queue only with an accepted transaction.
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> req_accept)
      else $error("queue push without an accepted transaction");

   // Two operations in one cycle are always a write followed by a summary.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push_cnt == 2'd2) |-> ((push0.code == elmd_pkg::OP_WRITE) &&
                              ((push1.code == elmd_pkg::OP_SUM_MAC) ||
                               (push1.code == elmd_pkg::OP_SUM_OVR))))
      else $error("bad operation pair");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the efuse logical map decoder. Physical efuse dumps are made
// of random well-formed records, with directed corner cases, broken dumps and
// stray bytes mixed in. A predictor in the monitor works out the map writes
// and the dump summaries, and each response transaction is checked against
// them field by field. The MAC offset register is changed between phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int PHY_BYTES    = 512;
   localparam int PROT_BYTES   = 96;
   localparam int LOG_BYTES    = 512;
   localparam int REGION_END   = (PHY_BYTES > PROT_BYTES) ? (PHY_BYTES - PROT_BYTES) : 0;
   localparam int ITEM_TARGET  = 1400;
   localparam int PHASES       = 6;
   localparam int DRAIN_CYCLES = 12;
   localparam int IDLE_PCT     = 9;

   // Parser position as the predictor tracks it.
   typedef enum logic [1:0] {P_IDLE, P_HEAD, P_HEAD_EXT, P_DATA} parse_state_type;

   typedef struct packed {
      logic       first;
      logic [7:0] data;
   } phy_item_type;

   typedef struct packed {
      logic        kind;
      logic [8:0]  log_index;
      logic [7:0]  log_byte;
      logic [1:0]  status;
      logic [47:0] mac;
      logic [5:0]  cap;
      logic [4:0]  rfe;
      logic        pkg;
      logic        last;
   } map_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_first_byte = 1'b0;
   logic [7:0]  req_phy_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [8:0]  rsp_log_index;
   logic [7:0]  rsp_log_byte;
   logic [1:0]  rsp_status;
   logic [47:0] rsp_mac_address;
   logic [5:0]  rsp_xtal_trim;
   logic [4:0]  rsp_rf_front_end;
   logic        rsp_package_type;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [8:0]  csr_write_data = 9'd0;

   efuse_logical_map_decoder_top #(
      .PHY_BYTES (PHY_BYTES),
      .PROT_BYTES(PROT_BYTES),
      .LOG_BYTES (LOG_BYTES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_byte  (req_first_byte),
      .req_phy_byte    (req_phy_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_log_index   (rsp_log_index),
      .rsp_log_byte    (rsp_log_byte),
      .rsp_status      (rsp_status),
      .rsp_mac_address (rsp_mac_address),
      .rsp_xtal_trim   (rsp_xtal_trim),
      .rsp_rf_front_end(rsp_rf_front_end),
      .rsp_package_type(rsp_package_type),
      .rsp_last        (rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // Bytes waiting to be sent and results waiting to arrive.
   phy_item_type   phy_stream[$];
   map_result_type map_results_due[$];
   bit          req_busy = 0;
   bit          steady = 0;
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          writes_seen = 0;
   int          summaries_seen = 0;

   // Stimulus generator bookkeeping.
   int          items_made = 0;
   int          dump_pos = 0;
   logic [8:0]  gen_offset = 9'd208;

   // Predictor state, starting at its reset values.
   logic [8:0]      prd_mac_offset = 9'd208;
   parse_state_type prd_state = P_IDLE;
   int unsigned  prd_pos = 0;
   logic [7:0]   prd_held = 8'h00;
   logic [6:0]   prd_block = 7'd0;
   logic [3:0]   prd_mask = 4'hF;
   int unsigned  prd_slot = 0;
   logic         prd_half = 1'b0;
   logic [47:0]  prd_mac = '1;
   logic [7:0]   prd_cap = 8'hFF;
   logic [7:0]   prd_rfe = 8'hFF;

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // A MAC that was never written or is all zero is flagged.
   function automatic logic [1:0] mac_health();
      if (prd_mac == '0 || prd_mac == '1)
         return elmd_pkg::STAT_MAC;
      return elmd_pkg::STAT_OK;
   endfunction

   // Close the dump with a summary transaction.
   task automatic emit_summary(input logic [1:0] st);
      map_result_type r;
      r = '0;
      r.kind   = 1'b1;
      r.status = st;
      r.mac    = prd_mac;
      r.cap    = prd_cap[5:0];
      r.rfe    = prd_rfe[4:0];
      r.pkg    = prd_rfe[5];
      r.last   = 1'b1;
      map_results_due.push_back(r);
      prd_state = P_IDLE;
   endtask

   // Emit one logical map write and update the captured fields.
   task automatic emit_write(input int unsigned lidx, input logic [7:0] b);
      map_result_type r;
      int unsigned off;
      r = '0;
      r.log_index = lidx[8:0];
      r.log_byte  = b;
      map_results_due.push_back(r);
      off = prd_mac_offset;
      if (lidx >= off && lidx - off < elmd_pkg::MAC_BYTES)
         prd_mac[(5 - (lidx - off)) * 8 +: 8] = b;
      if (lidx == elmd_pkg::CAP_INDEX)
         prd_cap = b;
      if (lidx == elmd_pkg::RFE_INDEX)
         prd_rfe = b;
   endtask

   // Find the next present word; a word that does not fit ends the dump.
   task automatic next_word(input int unsigned start);
      int unsigned w;
      int unsigned lidx;
      bit found;
      found = 0;
      for (w = start; w < 4 && !found; w++) begin
         if (!prd_mask[w]) begin
            found = 1;
            lidx = prd_block * 8 + w * 2;
            if (prd_pos + 2 > REGION_END || lidx + 2 > LOG_BYTES) begin
               emit_summary(elmd_pkg::STAT_OVR);
            end else begin
               prd_state = P_DATA;
               prd_slot  = w;
               prd_half  = 1'b0;
            end
         end
      end
      if (!found) begin
         prd_state = P_HEAD;
         prd_slot  = 0;
         prd_half  = 1'b0;
         if (prd_pos >= REGION_END)
            emit_summary(mac_health());
      end
   endtask

   // Work out the results of one accepted physical byte.
   task automatic decode_phy_byte(input logic first, input logic [7:0] b);
      if (first) begin
         prd_mac   = '1;
         prd_cap   = 8'hFF;
         prd_rfe   = 8'hFF;
         prd_pos   = 0;
         prd_held  = 8'h00;
         prd_block = 7'd0;
         prd_mask  = 4'hF;
         prd_slot  = 0;
         prd_half  = 1'b0;
         prd_state = P_HEAD;
         // An empty region closes the dump on its first byte.
         if (REGION_END == 0) begin
            emit_summary(mac_health());
            return;
         end
      end
      case (prd_state)
         P_HEAD: begin
            if (b == elmd_pkg::TERM_BYTE) begin
               emit_summary(mac_health());
            end else begin
               prd_pos++;
               if (b[4:0] == elmd_pkg::EXT_CODE) begin
                  prd_held  = b;
                  prd_state = P_HEAD_EXT;
               end else begin
                  prd_block = {3'b000, b[7:4]};
                  prd_mask  = b[3:0];
                  next_word(0);
               end
            end
         end
         P_HEAD_EXT: begin
            if (b == elmd_pkg::TERM_BYTE) begin
               emit_summary(mac_health());
            end else begin
               prd_pos++;
               prd_block = {b[7:4], prd_held[7:5]};
               prd_mask  = b[3:0];
               next_word(0);
            end
         end
         P_DATA: begin
            emit_write(prd_block * 8 + prd_slot * 2 + prd_half, b);
            prd_pos++;
            if (!prd_half)
               prd_half = 1'b1;
            else
               next_word(prd_slot + 1);
         end
         default: begin
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------

   task automatic add_byte(input logic first, input logic [7:0] b, input bit counted);
      phy_item_type it;
      it.first = first;
      it.data  = b;
      phy_stream.push_back(it);
      dump_pos = first ? 1 : dump_pos + 1;
      if (counted)
         items_made++;
   endtask

   // Blocks near the captured fields are chosen most often.
   function automatic logic [6:0] pick_block();
      int r;
      int base;
      r = $urandom_range(99);
      base = gen_offset >> 3;
      if (r < 15)
         return 7'd23;
      if (r < 28)
         return 7'd25;
      if (r < 42)
         return base[6:0];
      if (r < 52)
         return (base < 127) ? base[6:0] + 7'd1 : base[6:0];
      if (r < 70)
         return 7'($urandom_range(15));
      if (r < 88)
         return 7'($urandom_range(63));
      return 7'($urandom_range(64, 127));
   endfunction

   // One record: a short or extended header and up to data_limit data bytes.
   task automatic add_record(input logic [6:0] blk, input logic [3:0] mask,
                             input bit want_ext, input logic first,
                             input int data_limit);
      int w;
      int sent;
      if (!want_ext && blk < 16 && !(mask == 4'hF && (!blk[0] || blk == 15))) begin
         add_byte(first, {blk[3:0], mask}, 1);
      end else begin
         add_byte(first, {blk[2:0], elmd_pkg::EXT_CODE}, 1);
         add_byte(1'b0, {blk[6:3], mask}, 1);
      end
      sent = 0;
      for (w = 0; w < 4; w++) begin
         if (!mask[w]) begin
            repeat (2) begin
               if (sent < data_limit)
                  add_byte(1'b0, 8'($urandom_range(255)), 1);
               sent++;
            end
         end
      end
   endtask

   // A short dump: records, then a terminator or a cut-off record.
   task automatic add_dump();
      int records;
      int r;
      int i;
      logic [2:0] lo;
      records = $urandom_range(1, 5);
      r = $urandom_range(99);
      lo = 3'($urandom_range(7));
      if (r < 4) begin
         add_byte(1'b1, elmd_pkg::TERM_BYTE, 1);
      end else begin
         for (i = 0; i < records; i++)
            add_record(pick_block(), 4'($urandom_range(15)), $urandom_range(3) == 0,
                       i == 0, 8);
         if (r < 75) begin
            add_byte(1'b0, elmd_pkg::TERM_BYTE, 1);
         end else if (r < 88) begin
            add_byte(1'b0, {lo, elmd_pkg::EXT_CODE}, 1);
            add_byte(1'b0, elmd_pkg::TERM_BYTE, 1);
         end else begin
            // Broken dump: the next first byte arrives in the middle of a record.
            add_record(pick_block(), 4'h0, $urandom_range(1) == 1, 1'b0, $urandom_range(7));
         end
      end
      if (r < 88)
         repeat ($urandom_range(2)) add_byte(1'b0, 8'($urandom_range(255)), 0);
   endtask

   // A dump that runs up to the end of the usable region. The tail is either
   // an extended header straddling the end or a short header whose first word
   // ends exactly at it.
   task automatic add_fill_dump(input bit ext_tail);
      int target;
      bit opening;
      target = ext_tail ? REGION_END - 1 : REGION_END - 3;
      opening = 1;
      while (opening || dump_pos + 3 <= target) begin
         add_record(7'($urandom_range(14)), 4'hE, 0, opening, 8);
         opening = 0;
      end
      while (dump_pos < target)
         add_byte(1'b0, 8'h1F, 1);
      if (ext_tail)
         add_record(pick_block(), 4'($urandom_range(15)), 1, 1'b0, 8);
      else
         add_record(7'($urandom_range(14)), 4'($urandom_range(14)), 0, 1'b0, 8);
      repeat (2) add_byte(1'b0, 8'($urandom_range(255)), 0);
   endtask

   task automatic settle();
      while (phy_stream.size() != 0 || req_busy || map_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents the next byte and the response stall at falling edges
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && !req_busy) begin
         if (phy_stream.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            req_valid      <= 1'b1;
            req_first_byte <= phy_stream[0].first;
            req_phy_byte   <= phy_stream[0].data;
            req_busy = 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on accepted bytes and checks response transactions
   // ---------------------------------------------------------------------
   task automatic check_field(input string fname, input logic [47:0] want,
                              input logic [47:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, fname, want, got);
      end
   endtask

   always @(posedge clock) begin
      map_result_type want;
      if (!reset) begin
         if (csr_write_enable)
            prd_mac_offset = csr_write_data;
         if (req_valid && !req_stall) begin
            decode_phy_byte(req_first_byte, req_phy_byte);
            void'(phy_stream.pop_front());
            req_busy = 0;
            bytes_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (map_results_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transaction kind %0d index %h byte %h",
                        $time, rsp_kind, rsp_log_index, rsp_log_byte);
            end else begin
               want = map_results_due.pop_front();
               if (want.kind)
                  summaries_seen++;
               else
                  writes_seen++;
               check_field("kind", want.kind, rsp_kind);
               check_field("log_index", want.log_index, rsp_log_index);
               check_field("log_byte", want.log_byte, rsp_log_byte);
               check_field("status", want.status, rsp_status);
               check_field("mac_address", want.mac, rsp_mac_address);
               check_field("xtal_trim", want.cap, rsp_xtal_trim);
               check_field("rf_front_end", want.rfe, rsp_rf_front_end);
               check_field("package_type", want.pkg, rsp_package_type);
               check_field("last", want.last, rsp_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      // Corner cases: a stray byte before any dump, an empty dump, an
      // overrunning block, an all-zero MAC with the crystal trim, a terminator
      // in place of an extended header's second byte, and the rf front end byte.
      logic [8:0] opening_seq [0:26] = '{
         9'h012,
         9'h1FF,
         9'h11E, 9'h000, 9'h0FF, 9'h0EF, 9'h0F0,
         9'h05A,
         9'h14F, 9'h038, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
         9'h0EF, 9'h02E, 9'h0AB, 9'h0C5, 9'h00F, 9'h0FF,
         9'h12F, 9'h03D, 9'h03F, 9'h000, 9'h0FF
      };
      logic [8:0] offset_value;
      int p;
      int i;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            case (p)
               1: offset_value = 9'd0;
               2: offset_value = 9'd506;
               3: offset_value = 9'd208;
               default: offset_value = 9'($urandom_range(506));
            endcase
            @(negedge clock);
            csr_write_enable <= 1'b1;
            csr_write_data   <= offset_value;
            @(negedge clock);
            csr_write_enable <= 1'b0;
            gen_offset = offset_value;
         end
         // One phase runs with no idling on either side.
         steady = (p == 2);
         @(posedge clock);
         if (p == 0) begin
            for (i = 0; i < 27; i++)
               add_byte(opening_seq[i][8], opening_seq[i][7:0], 1);
         end
         if (p == 1)
            add_fill_dump(1);
         if (p == 4)
            add_fill_dump(0);
         while (items_made < (p + 1) * ITEM_TARGET / PHASES)
            add_dump();
      end
      settle();

      if (map_results_due.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected transactions never arrived", $time,
                  map_results_due.size());
      end
      $display("Sent %0d physical bytes over %0d MAC offset settings.", bytes_sent, PHASES);
      $display("Checked %0d map writes and %0d dump summaries.", writes_seen, summaries_seen);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
